[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("deadline timer queue check failed");

// Clocked assertion that is also checked during reset.
`define CHK_ASSERT_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("deadline timer queue reset check failed");

`endif

[hw/rtl/dtq_pkg.sv]
// Types, codes and sizes shared by the deadline timer queue modules.
package dtq_pkg;

   // Queue size and waiter tag width.
   localparam int QUEUE_DEPTH = 16;
   localparam int WAITER_BITS = 8;
   localparam logic [7:0] WAITER_MASK = 8'((64'd1 << WAITER_BITS) - 64'd1);

   // Stream widths.
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 144;

   // Operation codes.
   localparam logic [2:0] OP_ARM_ABS = 3'd0;
   localparam logic [2:0] OP_ARM_REL = 3'd1;
   localparam logic [2:0] OP_STEP    = 3'd2;
   localparam logic [2:0] OP_ADVANCE = 3'd3;
   localparam logic [2:0] OP_RESET   = 3'd4;

   // Result kinds.
   localparam logic [2:0] KIND_ARMED   = 3'd0;
   localparam logic [2:0] KIND_PAST    = 3'd1;
   localparam logic [2:0] KIND_FULL    = 3'd2;
   localparam logic [2:0] KIND_FIRED   = 3'd3;
   localparam logic [2:0] KIND_NONE    = 3'd4;
   localparam logic [2:0] KIND_RESET   = 3'd5;
   localparam logic [2:0] KIND_ADVANCE = 3'd6;

   // One queued waiter.
   typedef struct packed {
      logic        valid;
      logic [63:0] deadline;
      logic [31:0] order;
      logic [7:0]  tag;
   } entry_type;

   // Command broadcast from the sequencer to every cell.
   typedef struct packed {
      logic      ins;
      logic      pop;
      logic      clr;
      entry_type ent;
   } chain_cmd_type;

   // What the sequencer sees of the chain.
   typedef struct packed {
      entry_type head;
      entry_type second;
      logic      full;
   } chain_stat_type;

endpackage

[hw/rtl/deadline_timer_queue.sv]
// Deadline timer queue: a virtual clock with a sorted queue of waiter deadlines.
// Each request item carries one operation in req_tuser; the block answers with
// one or more result items, the final one marked by rsp_tlast. The queue is a
// row of QUEUE_DEPTH cells kept sorted, so the earliest waiter always sits in
// the first cell and an insert or removal updates all cells together. Each
// request is registered and decoded, then its results follow in turn, held
// while the output stalls: an arm, reset or empty step gives one result, a
// step firing k waiters gives k, and an advance firing k gives k + 1, at most
// QUEUE_DEPTH + 1. A new request is taken once the previous one's last result
// is in the output register. Reset clears the queue without a clearing pass.
module deadline_timer_queue (
   input  logic                           clock,
   input  logic                           reset,
   // Request channel.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata: time_value [63:0], waiter_id [71:64].
   input  logic [dtq_pkg::REQ_DATA_W-1:0] req_tdata,
   // tuser: operation [2:0].
   input  logic [2:0]                     req_tuser,
   // Result channel.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata: fired_waiter [7:0], current_time [71:8], timers_pending [72],
   // next_deadline [136:73], zero [143:137].
   output logic [dtq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: event_kind [2:0].
   output logic [2:0]                     rsp_tuser,
   // tlast: last_result.
   output logic                           rsp_tlast
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_EMIT   = 5'b00100,
      ST_STEP   = 5'b01000,
      ST_ADV    = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   logic [2:0]  op_ff, op_in;
   logic [63:0] tv_ff, tv_in;
   logic [7:0]  tag_ff, tag_in;
   logic [63:0] arm_dl_ff, arm_dl_in;
   logic [63:0] now_ff, now_in;
   logic [31:0] cnt_ff, cnt_in;
   logic [2:0]  kind_ff, kind_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  rsp_kind_ff, rsp_kind_in;
   logic [7:0]  rsp_tag_ff, rsp_tag_in;
   logic [63:0] rsp_now_ff, rsp_now_in;
   logic        rsp_pend_ff, rsp_pend_in;
   logic [63:0] rsp_next_ff, rsp_next_in;
   logic        rsp_last_ff, rsp_last_in;

   dtq_pkg::chain_cmd_type  cmd;
   dtq_pkg::chain_stat_type stat;

   logic        out_free;
   logic        load;
   logic        adv_fire;
   logic        step_last;
   logic [63:0] adv_now;

   dtq_chain u_chain (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .stat  (stat)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // Advance fires the head while it is due by the target, finishing a
   // group of equal deadlines even once time has reached the target.
   assign adv_fire  = stat.head.valid && (stat.head.deadline <= tv_ff) &&
                      ((now_ff < tv_ff) || (stat.head.deadline == now_ff));
   assign adv_now   = (now_ff < tv_ff) ? tv_ff : now_ff;
   assign step_last = !(stat.second.valid && (stat.second.deadline == now_ff));

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      tv_in     = tv_ff;
      tag_in    = tag_ff;
      arm_dl_in = arm_dl_ff;
      now_in    = now_ff;
      cnt_in    = cnt_ff;
      kind_in   = kind_ff;

      cmd           = '0;
      cmd.ent.valid = 1'b1;
      cmd.ent.deadline = arm_dl_ff;
      cmd.ent.order = cnt_ff + 32'd1;
      cmd.ent.tag   = tag_ff;

      load        = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_tag_in  = rsp_tag_ff;
      rsp_now_in  = rsp_now_ff;
      rsp_pend_in = rsp_pend_ff;
      rsp_next_in = rsp_next_ff;
      rsp_last_in = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in  = req_tuser;
               tv_in  = req_tdata[63:0];
               tag_in = req_tdata[71:64] & dtq_pkg::WAITER_MASK;
               if (req_tuser == dtq_pkg::OP_ARM_REL) begin
                  arm_dl_in = now_ff + req_tdata[63:0];
               end else begin
                  arm_dl_in = req_tdata[63:0];
               end
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            state_in = ST_EMIT;
            kind_in  = dtq_pkg::KIND_NONE;
            unique case (op_ff) inside
               dtq_pkg::OP_ARM_ABS, dtq_pkg::OP_ARM_REL: begin
                  if (arm_dl_ff <= now_ff) begin
                     kind_in = dtq_pkg::KIND_PAST;
                  end else if (stat.full) begin
                     kind_in = dtq_pkg::KIND_FULL;
                  end else begin
                     cmd.ins = 1'b1;
                     cnt_in  = cnt_ff + 32'd1;
                     kind_in = dtq_pkg::KIND_ARMED;
                  end
               end
               dtq_pkg::OP_STEP: begin
                  if (stat.head.valid) begin
                     now_in   = stat.head.deadline;
                     state_in = ST_STEP;
                  end
               end
               dtq_pkg::OP_ADVANCE: begin
                  state_in = ST_ADV;
               end
               dtq_pkg::OP_RESET: begin
                  now_in  = tv_ff;
                  cnt_in  = 32'd0;
                  cmd.clr = 1'b1;
                  kind_in = dtq_pkg::KIND_RESET;
               end
               default: begin
                  kind_in = dtq_pkg::KIND_NONE;
               end
            endcase
         end

         ST_EMIT: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_kind_in = kind_ff;
               case (kind_ff) inside
                  dtq_pkg::KIND_ARMED, dtq_pkg::KIND_PAST, dtq_pkg::KIND_FULL: begin
                     rsp_tag_in = tag_ff;
                  end
                  default: begin
                     rsp_tag_in = 8'd0;
                  end
               endcase
               rsp_now_in  = now_ff;
               rsp_pend_in = stat.head.valid;
               rsp_next_in = stat.head.valid ? stat.head.deadline : now_ff;
               rsp_last_in = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         ST_STEP: begin
            // The head is due; the view after the pop is the second cell.
            if (out_free) begin
               load        = 1'b1;
               cmd.pop     = 1'b1;
               rsp_kind_in = dtq_pkg::KIND_FIRED;
               rsp_tag_in  = stat.head.tag;
               rsp_now_in  = now_ff;
               rsp_pend_in = stat.second.valid;
               rsp_next_in = stat.second.valid ? stat.second.deadline : now_ff;
               rsp_last_in = step_last;
               if (step_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         ST_ADV: begin
            if (out_free) begin
               load = 1'b1;
               if (adv_fire) begin
                  cmd.pop     = 1'b1;
                  now_in      = stat.head.deadline;
                  rsp_kind_in = dtq_pkg::KIND_FIRED;
                  rsp_tag_in  = stat.head.tag;
                  rsp_now_in  = stat.head.deadline;
                  rsp_pend_in = stat.second.valid;
                  rsp_next_in = stat.second.valid ? stat.second.deadline
                                                  : stat.head.deadline;
                  rsp_last_in = 1'b0;
               end else begin
                  now_in      = adv_now;
                  rsp_kind_in = dtq_pkg::KIND_ADVANCE;
                  rsp_tag_in  = 8'd0;
                  rsp_now_in  = adv_now;
                  rsp_pend_in = stat.head.valid;
                  rsp_next_in = stat.head.valid ? stat.head.deadline : adv_now;
                  rsp_last_in = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The output register holds a result until it is taken.
   assign rsp_valid_in = load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         now_ff       <= 64'd0;
         cnt_ff       <= 32'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         now_ff       <= now_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Request and result payload registers.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      tv_ff       <= tv_in;
      tag_ff      <= tag_in;
      arm_dl_ff   <= arm_dl_in;
      kind_ff     <= kind_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_tag_ff  <= rsp_tag_in;
      rsp_now_ff  <= rsp_now_in;
      rsp_pend_ff <= rsp_pend_in;
      rsp_next_ff <= rsp_next_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_next_ff, rsp_pend_ff, rsp_now_ff, rsp_tag_ff};

endmodule

[hw/rtl/dtq_cell.sv]
// One cell of the sorted queue: holds one entry and trades it with its neighbors.
module dtq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  dtq_pkg::chain_cmd_type cmd,
   input  dtq_pkg::entry_type     prev_ent,
   input  logic                   prev_lt,
   input  dtq_pkg::entry_type     next_ent,
   output dtq_pkg::entry_type     ent,
   output logic                   lt
);

   dtq_pkg::entry_type ent_ff;
   dtq_pkg::entry_type ent_in;

   // The new entry sorts ahead of this one; an empty cell counts as latest.
   assign lt = !ent_ff.valid ||
               (cmd.ent.deadline < ent_ff.deadline) ||
               ((cmd.ent.deadline == ent_ff.deadline) && (cmd.ent.order < ent_ff.order));

   // Clear, shift toward the head, or make room for an insert.
   always_comb begin
      ent_in = ent_ff;
      if (cmd.clr) begin
         ent_in.valid = 1'b0;
      end else if (cmd.pop) begin
         ent_in = next_ent;
      end else if (cmd.ins && lt) begin
         if (prev_lt) begin
            ent_in = prev_ent;
         end else begin
            ent_in = cmd.ent;
         end
      end
   end

   // Only the valid bit needs a reset value.
   always_ff @(posedge clock) begin
      if (reset) begin
         ent_ff.valid <= 1'b0;
      end else begin
         ent_ff <= ent_in;
      end
   end

   assign ent = ent_ff;

endmodule

[hw/rtl/dtq_chain.sv]
// Row of queue cells kept sorted by deadline and then arming order.
module dtq_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  dtq_pkg::chain_cmd_type  cmd,
   output dtq_pkg::chain_stat_type stat
);

   localparam int Q = dtq_pkg::QUEUE_DEPTH;

   dtq_pkg::entry_type ents [Q];
   logic               lts  [Q];

   // Each cell sees its neighbors; the ends are tied to an empty entry.
   for (genvar i = 0; i < Q; i++) begin : g_cell
      dtq_pkg::entry_type prev_ent;
      dtq_pkg::entry_type next_ent;
      logic               prev_lt;

      if (i == 0) begin : g_first
         assign prev_ent = '0;
         assign prev_lt  = 1'b0;
      end else begin : g_inner
         assign prev_ent = ents[i-1];
         assign prev_lt  = lts[i-1];
      end

      if (i == Q - 1) begin : g_last
         assign next_ent = '0;
      end else begin : g_more
         assign next_ent = ents[i+1];
      end

      dtq_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .prev_ent (prev_ent),
         .prev_lt  (prev_lt),
         .next_ent (next_ent),
         .ent      (ents[i]),
         .lt       (lts[i])
      );
   end

   // The head is the earliest entry; a valid last cell means the queue is full.
   assign stat.head   = ents[0];
   assign stat.second = ents[1];
   assign stat.full   = ents[Q-1].valid;

endmodule

[hw/rtl/dtq_checker.sv]
// Port-level checks for the deadline timer queue and their bind.
`include "assert_macros.svh"

module dtq_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [dtq_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [2:0]                     req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [dtq_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic [2:0]                     rsp_tuser,
   input logic                           rsp_tlast
);

   // A stalled result item holds its payload.
   `CHK_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast))

   // No result is shown in the cycle after reset.
   `CHK_ASSERT_NR(a_reset_quiet, clock, reset |=> !rsp_tvalid)

   // Only fired results can be followed by more results of the same request.
   `CHK_ASSERT(a_only_fired_open, clock, reset, rsp_tvalid && (rsp_tuser != dtq_pkg::KIND_FIRED) |-> rsp_tlast)

   // An empty queue reports the current time as the next deadline.
   `CHK_ASSERT(a_empty_next, clock, reset, rsp_tvalid && !rsp_tdata[72] |-> rsp_tdata[136:73] == rsp_tdata[71:8])

   // The event kind never takes an unused code.
   `CHK_ASSERT(a_kind_range, clock, reset, rsp_tvalid |-> rsp_tuser <= dtq_pkg::KIND_ADVANCE)

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);

[tb/deadline_timer_queue_tb.sv]
// Self-checking testbench for the deadline timer queue: directed and random timer operations.
module deadline_timer_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 10;
   // Cycles with no item moving on either side before the run is abandoned.
   localparam int QUIET_LIMIT = 2000;
   // Cycles to watch for stray results once nothing more is owed.
   localparam int TAIL_CYCLES = dtq_pkg::QUEUE_DEPTH + 8;
   localparam int MAX_REPORTS = 30;
   // First of the operation codes that the block does not define.
   localparam logic [2:0] OP_SPARE_LO = 3'd5;
   localparam int SPARE_CODES = 3;
   localparam logic [63:0] TIME_MAX = 64'hFFFF_FFFF_FFFF_FFFF;

   // One result item as the block should produce it.
   typedef struct packed {
      logic [2:0]  kind;
      logic [7:0]  tag;
      logic [63:0] now_us;
      logic        pending;
      logic [63:0] next_dl;
      logic        last;
   } timer_event_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   logic [dtq_pkg::REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]                     req_tuser = '0;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic [dtq_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [2:0]                     rsp_tuser;
   logic                           rsp_tlast;

   // Predicted timer state.
   logic [63:0] virt_now;
   logic [31:0] arm_seq;
   logic [63:0] slot_deadline [dtq_pkg::QUEUE_DEPTH];
   logic [31:0] slot_order [dtq_pkg::QUEUE_DEPTH];
   logic [7:0]  slot_tag [dtq_pkg::QUEUE_DEPTH];
   bit          slot_live [dtq_pkg::QUEUE_DEPTH];

   // Results still owed by the block, oldest first.
   timer_event_type owed_events [$];

   int fail_count = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit sender_idling = 1'b0;
   bit receiver_idling = 1'b0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   deadline_timer_queue uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Index of the earliest live waiter (deadline, then arming order), or -1.
   function automatic int earliest_waiter();
      int best;
      best = -1;
      for (int i = 0; i < dtq_pkg::QUEUE_DEPTH; i++) begin
         if (slot_live[i] && (best < 0 || slot_deadline[i] < slot_deadline[best] ||
             (slot_deadline[i] == slot_deadline[best] && slot_order[i] < slot_order[best]))) begin
            best = i;
         end
      end
      return best;
   endfunction

   // Record one result with the queue status as it stands now.
   function automatic void owe_event(logic [2:0] kind, logic [7:0] tag);
      timer_event_type ev;
      int e;
      e = earliest_waiter();
      ev.kind = kind;
      ev.tag = tag;
      ev.now_us = virt_now;
      ev.pending = (e >= 0);
      ev.next_dl = (e >= 0) ? slot_deadline[e] : virt_now;
      ev.last = 1'b0;
      owed_events.insert(owed_events.size(), ev);
   endfunction

   // Jump to the earliest deadline and fire everything due there.
   function automatic void fire_earliest();
      int e;
      e = earliest_waiter();
      if (e >= 0) begin
         virt_now = slot_deadline[e];
         e = earliest_waiter();
         while (e >= 0 && slot_deadline[e] <= virt_now) begin
            slot_live[e] = 1'b0;
            owe_event(dtq_pkg::KIND_FIRED, slot_tag[e]);
            e = earliest_waiter();
         end
      end
   endfunction

   function automatic void arm_waiter(logic [63:0] deadline, logic [7:0] tag);
      int s;
      s = -1;
      if (deadline <= virt_now) begin
         owe_event(dtq_pkg::KIND_PAST, tag);
      end else begin
         for (int i = dtq_pkg::QUEUE_DEPTH - 1; i >= 0; i--) begin
            if (!slot_live[i]) begin
               s = i;
            end
         end
         if (s < 0) begin
            owe_event(dtq_pkg::KIND_FULL, tag);
         end else begin
            arm_seq = arm_seq + 32'd1;
            slot_deadline[s] = deadline;
            slot_order[s] = arm_seq;
            slot_tag[s] = tag;
            slot_live[s] = 1'b1;
            owe_event(dtq_pkg::KIND_ARMED, tag);
         end
      end
   endfunction

   // Apply one accepted operation to the predicted state and owe its results.
   function automatic void apply_timer_op(logic [2:0] op, logic [63:0] tv, logic [7:0] raw_tag);
      logic [7:0] tag;
      int e;
      tag = raw_tag & dtq_pkg::WAITER_MASK;
      case (op)
         dtq_pkg::OP_ARM_ABS: begin
            arm_waiter(tv, tag);
         end
         dtq_pkg::OP_ARM_REL: begin
            arm_waiter(virt_now + tv, tag);
         end
         dtq_pkg::OP_STEP: begin
            if (earliest_waiter() < 0) begin
               owe_event(dtq_pkg::KIND_NONE, 8'd0);
            end else begin
               fire_earliest();
            end
         end
         dtq_pkg::OP_ADVANCE: begin
            while (virt_now < tv) begin
               e = earliest_waiter();
               if (e < 0 || slot_deadline[e] > tv) begin
                  virt_now = tv;
                  break;
               end
               fire_earliest();
            end
            owe_event(dtq_pkg::KIND_ADVANCE, 8'd0);
         end
         dtq_pkg::OP_RESET: begin
            virt_now = tv;
            arm_seq = '0;
            for (int i = 0; i < dtq_pkg::QUEUE_DEPTH; i++) begin
               slot_live[i] = 1'b0;
            end
            owe_event(dtq_pkg::KIND_RESET, 8'd0);
         end
         default: begin
            owe_event(dtq_pkg::KIND_NONE, 8'd0);
         end
      endcase
      // The final result of this operation carries the last flag.
      owed_events[owed_events.size() - 1].last = 1'b1;
   endfunction

   // Offer one operation, wait for it to be taken, then predict its results.
   task automatic send_op(input logic [2:0] op, input logic [63:0] tv, input logic [7:0] tag);
      int gap;
      if (sender_idling && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         req_tvalid = 1'b0;
         req_tdata = {8'($urandom), $urandom, $urandom};
         req_tuser = 3'($urandom);
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = {tag, tv};
      req_tuser = op;
      do begin
         @(posedge clock);
      end while (!req_tready);
      apply_timer_op(op, tv, tag);
   endtask

   task automatic check_field(input string name, input logic [63:0] exp_v,
                              input logic [63:0] act_v);
      if (exp_v !== act_v) begin
         if (fail_count < MAX_REPORTS) begin
            $display("%0t: %s expected %h actual %h", $realtime, name, exp_v, act_v);
         end
         fail_count++;
      end
   endtask

   // Compare every result item with the oldest owed one.
   always @(posedge clock) begin
      timer_event_type ev;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_events.size() == 0) begin
            if (fail_count < MAX_REPORTS) begin
               $display("%0t: unexpected result expected none actual kind %0d data %h",
                        $realtime, rsp_tuser, rsp_tdata);
            end
            fail_count++;
         end else begin
            ev = owed_events.pop_front();
            check_field("event_kind", 64'(ev.kind), 64'(rsp_tuser));
            check_field("fired_waiter", 64'(ev.tag), 64'(rsp_tdata[7:0]));
            check_field("current_time", ev.now_us, rsp_tdata[71:8]);
            check_field("timers_pending", 64'(ev.pending), 64'(rsp_tdata[72]));
            check_field("next_deadline", ev.next_dl, rsp_tdata[136:73]);
            check_field("pad bits", 64'd0, 64'(rsp_tdata[143:137]));
            check_field("last_result", 64'(ev.last), 64'(rsp_tlast));
         end
      end
   end

   // Result side back-pressure in random bursts.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (receiver_idling && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 8);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Give up when no item moves for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Empty queue behavior, unused codes and a time reset.
   task automatic test_empty_queue();
      send_op(dtq_pkg::OP_STEP, 64'd0, 8'd0);
      send_op(dtq_pkg::OP_ADVANCE, 64'd0, 8'hFF);
      for (int k = 0; k < SPARE_CODES; k++) begin
         send_op(OP_SPARE_LO + 3'(k), {$urandom, $urandom}, 8'($urandom));
      end
      send_op(dtq_pkg::OP_RESET, 64'd1000, 8'd0);
   endtask

   // Deadlines at or before now, including a relative delay that wraps.
   task automatic test_past_deadlines();
      send_op(dtq_pkg::OP_ARM_ABS, virt_now, 8'hFF);
      send_op(dtq_pkg::OP_ARM_REL, 64'hFFFF_FFFF_FFFF_FF00, 8'h00);
      send_op(dtq_pkg::OP_ARM_REL, 64'd0, 8'h5A);
   endtask

   // Fill the queue with tied deadlines, overflow it, then drain it in one advance.
   task automatic test_full_queue();
      send_op(dtq_pkg::OP_ARM_ABS, TIME_MAX, 8'h00);
      for (int k = 1; k <= 5; k++) begin
         send_op(dtq_pkg::OP_ARM_ABS, virt_now + 64'd1000, 8'(k));
      end
      for (int k = 0; k < dtq_pkg::QUEUE_DEPTH - 6; k++) begin
         send_op(dtq_pkg::OP_ARM_REL, 64'd100 + 64'((k % 3) * 50), 8'h10 + 8'(k));
      end
      send_op(dtq_pkg::OP_ARM_ABS, virt_now + 64'd3, 8'hAA);
      send_op(dtq_pkg::OP_ADVANCE, TIME_MAX, 8'd0);
      send_op(dtq_pkg::OP_RESET, 64'd0, 8'd0);
   endtask

   // Mostly small, well-formed timing traffic with some far jumps and noise.
   task automatic run_random_ops(input int n_items);
      int pick;
      logic [2:0] op;
      logic [63:0] tv;
      logic [7:0] tag;
      for (int n = 0; n < n_items; n++) begin
         pick = $urandom_range(0, 99);
         tag = 8'($urandom);
         tv = {$urandom, $urandom};
         if (pick < 36) begin
            op = dtq_pkg::OP_ARM_REL;
            tv = 64'($urandom_range(0, 40));
         end else if (pick < 51) begin
            op = dtq_pkg::OP_ARM_ABS;
            tv = virt_now + 64'($urandom_range(0, 45)) - 64'd5;
         end else if (pick < 64) begin
            op = dtq_pkg::OP_STEP;
         end else if (pick < 79) begin
            op = dtq_pkg::OP_ADVANCE;
            tv = virt_now + 64'($urandom_range(0, 60));
         end else if (pick < 82) begin
            op = dtq_pkg::OP_RESET;
            if ($urandom_range(0, 1) == 1) begin
               tv = 64'($urandom_range(0, 1000));
            end
         end else if (pick < 90) begin
            op = ($urandom_range(0, 1) == 1) ? dtq_pkg::OP_ARM_ABS : dtq_pkg::OP_ARM_REL;
         end else if (pick < 94) begin
            op = dtq_pkg::OP_ADVANCE;
         end else if (pick < 97) begin
            op = dtq_pkg::OP_STEP;
         end else begin
            op = OP_SPARE_LO + 3'($urandom_range(0, SPARE_CODES - 1));
         end
         send_op(op, tv, tag);
      end
   endtask

   task automatic test_random_with_stalls();
      sender_idling = 1'b1;
      receiver_idling = 1'b1;
      run_random_ops(75);
   endtask

   task automatic test_random_full_rate();
      sender_idling = 1'b0;
      receiver_idling = 1'b0;
      run_random_ops(30);
   endtask

   initial begin
      virt_now = '0;
      arm_seq = '0;
      for (int i = 0; i < dtq_pkg::QUEUE_DEPTH; i++) begin
         slot_live[i] = 1'b0;
      end
      repeat (RESET_CYCLES) @(negedge clock);
      reset = 1'b0;

      sender_idling = 1'b1;
      receiver_idling = 1'b1;
      test_empty_queue();
      test_past_deadlines();
      test_full_queue();
      test_random_with_stalls();
      test_random_full_rate();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (owed_events.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

[deadline_timer_queue.f]
+incdir+hw/rtl
hw/rtl/dtq_pkg.sv
hw/rtl/dtq_cell.sv
hw/rtl/dtq_chain.sv
hw/rtl/deadline_timer_queue.sv
hw/rtl/dtq_checker.sv
tb/deadline_timer_queue_tb.sv
